@@ src/swmm_pkg.sv @@
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types and constants for the sliding-window median/mean filter.
// ----------------------------------------------------------------------------
package swmm_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [0:0] {
    MODE_MEDIAN = 1'b0,
    MODE_MEAN   = 1'b1
  } mode_e;

endpackage

@@ src/sliding_window_median_mean.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median_mean
// Median or rounded mean over a sliding window of timestamped Q16.16 samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one sample word: a time
//   stamp and a signed Q16.16 value. Output channel (out_valid_o / out_stall_i)
//   carries the centre time stamp of the window and the filtered value.
//   The first WINDOW-1 samples after reset only fill the window; every sample
//   after that yields exactly one result word.
//   cfg_valid_i / cfg_ready_o writes filter_mode (0 median, 1 mean); it is
//   always ready; the user must write it only while the filter is idle.
// Timing:
//   Throughput is one word per cycle while out_stall_i is low. An accepted
//   word passes the window shift register, then rank/sum stage, magnitude
//   stage, split reciprocal multiply stage, and the output register.
// Reset:
//   Clears the fill count and all stage valids; filter_mode returns to mean.
// Backpressure:
//   out_stall_i holds the output word; stages fill up behind it and
//   in_stall_o rises only when the stage after the window is full and blocked.
// ----------------------------------------------------------------------------
module sliding_window_median_mean
  import swmm_pkg::*;
#(
  parameter int unsigned WINDOW = 5
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  data_t        sample_time_i,
  input  data_t        sample_value_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output data_t        centre_time_o,
  output data_t        filtered_value_o
);

  localparam int unsigned FillW  = $clog2(WINDOW + 1);
  localparam int unsigned RankW  = $clog2(WINDOW);
  localparam int unsigned SumW   = DATA_W + $clog2(WINDOW);
  localparam int unsigned Shift  = SumW + $clog2(WINDOW);
  localparam int unsigned MulW   = SumW + 1;
  localparam logic [63:0] Recip  = ((64'd1 << Shift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam int unsigned ALo    = SumW / 2;
  localparam int unsigned AHi    = SumW - ALo;
  localparam int unsigned BLo    = MulW / 2;
  localparam int unsigned BHi    = MulW - BLo;
  localparam int unsigned ProdW  = SumW + MulW;
  localparam logic [MulW-1:0] RecipM = Recip[MulW-1:0];
  localparam int unsigned Centre = WINDOW / 2;

  // config
  mode_e mode_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MEAN;
    end else if (cfg_valid_i) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  // handshake chain
  logic acc_in, pend_q, v1_q, v2_q, v3_q, out_vld_q;
  logic rdy1, rdy2, rdy3, rdy_out;

  assign rdy_out    = !out_vld_q || !out_stall_i;
  assign rdy3       = !v3_q || rdy_out;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = pend_q && !rdy1;
  assign acc_in     = in_valid_i && !in_stall_o;

  // window shift register, oldest at index 0
  data_t            win_val_q [WINDOW];
  data_t            win_time_q[WINDOW];
  logic [FillW-1:0] fill_q;

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        win_val_q[i]  <= win_val_q[i+1];
        win_time_q[i] <= win_time_q[i+1];
      end
      win_val_q[WINDOW-1]  <= sample_value_i;
      win_time_q[WINDOW-1] <= sample_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pend_q <= 1'b0;
    end else begin
      if (acc_in && fill_q != FillW'(WINDOW)) begin
        fill_q <= fill_q + FillW'(1);
      end
      if (acc_in) begin
        pend_q <= (fill_q >= FillW'(WINDOW - 1));
      end else if (rdy1) begin
        pend_q <= 1'b0;
      end
    end
  end

  // stage 1: rank select and sum
  logic [RankW-1:0]       rank [WINDOW];
  data_t                  med_d;
  logic signed [SumW-1:0] sum_d;

  always_comb begin
    med_d = '0;
    sum_d = '0;
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if ((win_val_q[j] < win_val_q[i]) ||
            ((win_val_q[j] == win_val_q[i]) && (j < i))) begin
          rank[i] = rank[i] + RankW'(1);
        end
      end
      if (rank[i] == RankW'(Centre)) begin
        med_d = med_d | win_val_q[i];
      end
      sum_d = sum_d + SumW'(win_val_q[i]);
    end
  end

  logic signed [SumW-1:0] sum1_q;
  data_t                  med1_q, time1_q;
  mode_e                  mode1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      sum1_q  <= sum_d;
      med1_q  <= med_d;
      time1_q <= win_time_q[Centre];
      mode1_q <= mode_q;
    end
  end

  // stage 2: rounded magnitude
  logic [SumW-1:0] mag_d;
  logic            neg_d;

  assign neg_d = sum1_q[SumW-1];
  assign mag_d = (neg_d ? (SumW'(0) - SumW'(sum1_q)) : SumW'(sum1_q))
                 + SumW'(WINDOW / 2);

  logic [SumW-1:0] mag2_q;
  logic            neg2_q;
  data_t           med2_q, time2_q;
  mode_e           mode2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      mag2_q  <= mag_d;
      neg2_q  <= neg_d;
      med2_q  <= med1_q;
      time2_q <= time1_q;
      mode2_q <= mode1_q;
    end
  end

  // stage 3: partial products of magnitude times reciprocal
  logic [ALo+BLo-1:0] pll_q;
  logic [ALo+BHi-1:0] plh_q;
  logic [AHi+BLo-1:0] phl_q;
  logic [AHi+BHi-1:0] phh_q;
  logic               neg3_q;
  data_t              med3_q, time3_q;
  mode_e              mode3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      pll_q   <= (ALo+BLo)'(mag2_q[ALo-1:0])    * (ALo+BLo)'(RecipM[BLo-1:0]);
      plh_q   <= (ALo+BHi)'(mag2_q[ALo-1:0])    * (ALo+BHi)'(RecipM[MulW-1:BLo]);
      phl_q   <= (AHi+BLo)'(mag2_q[SumW-1:ALo]) * (AHi+BLo)'(RecipM[BLo-1:0]);
      phh_q   <= (AHi+BHi)'(mag2_q[SumW-1:ALo]) * (AHi+BHi)'(RecipM[MulW-1:BLo]);
      neg3_q  <= neg2_q;
      med3_q  <= med2_q;
      time3_q <= time2_q;
      mode3_q <= mode2_q;
    end
  end

  // output stage: combine, shift, sign, select
  logic [ProdW-1:0]  prod;
  logic [DATA_W-1:0] quot, mean_d;

  assign prod   = (ProdW'(phh_q) << (ALo + BLo)) + (ProdW'(phl_q) << ALo)
                + (ProdW'(plh_q) << BLo) + ProdW'(pll_q);
  assign quot   = prod[Shift +: DATA_W];
  assign mean_d = neg3_q ? (DATA_W'(0) - quot) : quot;

  data_t out_time_q, out_val_q;

  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      out_time_q <= time3_q;
      out_val_q  <= (mode3_q == MODE_MEDIAN) ? med3_q : data_t'(mean_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= pend_q;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy_out) begin
        out_vld_q <= v3_q;
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign centre_time_o    = out_time_q;
  assign filtered_value_o = out_val_q;

endmodule
